// ===== hdl/heightmap_triangle_height_sample_macros.svh =====
// assertion macros for the height sampler
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLE_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_SAMPLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// implication checked in the same cycle
`define HMTH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hmth: same-cycle check failed");
// implication checked in the following cycle
`define HMTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hmth: next-cycle check failed");
`else
`define HMTH_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HMTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/hmth_pkg.sv =====
package hmth_pkg;

	// grid store geometry
	localparam int GRID_SIDE  = 64;
	localparam int DEPTH      = GRID_SIDE * GRID_SIDE;
	localparam int ADDR_W     = $clog2(DEPTH);

	// field widths
	localparam int ROW_W      = 6;
	localparam int HGT_W      = 16;
	localparam int POS_W      = 24;
	localparam int OUT_W      = 24;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int SP_W       = 8;
	localparam int VERTS_W    = 7;

	// vertex count limits
	localparam int VERTS_MIN  = 2;
	localparam int VERTS_MAX  = (GRID_SIDE > (1 << VERTS_W) - 1) ? (1 << VERTS_W) - 1 : GRID_SIDE;

	// internal arithmetic widths
	localparam int OFS_W      = POS_W + 2;
	localparam int NUM_W      = POS_W;
	localparam int CELL_W     = NUM_W - FRAC_W;
	localparam int CNT_W      = $clog2(NUM_W);
	localparam int SUM_W      = HGT_W + FRAC_W + 3;
	localparam int LIN_W      = (2 * VERTS_W > ADDR_W) ? 2 * VERTS_W : ADDR_W;
	localparam int RD_CNT_W   = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORNER_X  = 3'd0,
		REG_CORNER_Z  = 3'd1,
		REG_SPACING   = 3'd2,
		REG_VERTS_ROW = 3'd3,
		REG_VERTS_COL = 3'd4
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_CHK  = 6'b000100,
		ST_READ = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_SUM  = 6'b100000
	} state_t;

	// limit a vertex count to the usable grid range
	function automatic logic [VERTS_W-1:0] clamp_verts(input logic [VERTS_W-1:0] v);
		logic [VERTS_W-1:0] r;
		if (v < VERTS_W'(VERTS_MIN))
			r = VERTS_W'(VERTS_MIN);
		else if (v > VERTS_W'(VERTS_MAX))
			r = VERTS_W'(VERTS_MAX);
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== hdl/heightmap_triangle_height_sample.sv =====
// channel   dir  transfer                 word
// command   in   start && !busy           operation, entry_row, entry_col, entry_value,
//                                         pos_x, pos_z
// result    out  done, one cycle          height_q8, out_of_range
// config    in   cfg_valid && cfg_ready   cfg_index, cfg_data
//
// a height write, or a query left of or above the grid corner, gives done in the cycle
// after it is taken; a query past the far grid edge gives done after the divide and the
// bounds check, any other query after a 24-step bit-serial divide by the cell spacing, then
// four corner reads through the single read port of the height memory.
// busy is high while a query is in flight; one item is worked at a time.
// arst_n clears the sequencer, the result strobe and the result and configuration registers;
// the height memory and datapath registers have no reset. cfg_ready is always high. results cannot be held off.
`include "heightmap_triangle_height_sample_macros.svh"

module heightmap_triangle_height_sample
	import hmth_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    operation,
	input  logic [ROW_W-1:0]        entry_row,
	input  logic [ROW_W-1:0]        entry_col,
	input  logic [HGT_W-1:0]        entry_value,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_z,
	output logic                    done,
	output logic [OUT_W-1:0]        height_q8,
	output logic                    out_of_range,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	// configuration registers
	logic signed [CFG_DATA_W-1:0] corner_x_q;
	logic signed [CFG_DATA_W-1:0] corner_z_q;
	logic [SP_W-1:0]              spacing_q;
	logic [VERTS_W-1:0]           vrow_q;
	logic [VERTS_W-1:0]           vcol_q;

	// sequencer
	state_t                       state_q;
	logic [CNT_W-1:0]             div_cnt_q;
	logic [RD_CNT_W-1:0]          rd_cnt_q;

	// result registers
	logic                         done_q;
	logic [OUT_W-1:0]             height_q;
	logic                         oor_q;

	// datapath registers
	logic [NUM_W-1:0]             numx_q;
	logic [NUM_W-1:0]             numz_q;
	logic [SP_W-1:0]              remx_q;
	logic [SP_W-1:0]              remz_q;
	logic [ADDR_W-1:0]            base_q;
	logic [FRAC_W-1:0]            fx_q;
	logic [FRAC_W-1:0]            fz_q;
	logic [HGT_W-1:0]             corner_q [4];
	logic [OUT_W-1:0]             basev_q;
	logic signed [SUM_W-1:0]      p1_q;
	logic signed [SUM_W-1:0]      p2_q;

	// height memory
	logic [HGT_W-1:0]             mem [DEPTH];
	logic [HGT_W-1:0]             rd_q;
	logic [ADDR_W-1:0]            raddr;
	logic [ADDR_W-1:0]            waddr;
	logic                         mem_we;
	logic [LIN_W-1:0]             wlin;

	// combinational helpers
	logic                         accept;
	logic [VERTS_W-1:0]           stride;
	logic [VERTS_W-1:0]           rows;
	logic [SP_W-1:0]              sp;
	logic signed [OFS_W-1:0]      tx;
	logic signed [OFS_W-1:0]      tz;
	logic                         neg_ofs;
	logic [SP_W:0]                trial_x;
	logic [SP_W:0]                trial_z;
	logic                         ge_x;
	logic                         ge_z;
	logic [SP_W:0]                diffx;
	logic [SP_W:0]                diffz;
	logic [CELL_W-1:0]            col_c;
	logic [CELL_W-1:0]            row_c;
	logic                         grid_oor;
	logic [LIN_W-1:0]             rlin;
	logic [RD_CNT_W-1:0]          cap_idx;
	logic [FRAC_W:0]              fsum;
	logic                         upper;
	logic [HGT_W-1:0]             e_v;
	logic [HGT_W-1:0]             g1_v;
	logic [HGT_W-1:0]             g2_v;
	logic [FRAC_W:0]              w1;
	logic [FRAC_W:0]              w2;
	logic signed [HGT_W:0]        diff1;
	logic signed [HGT_W:0]        diff2;
	logic signed [SUM_W-1:0]      p1_c;
	logic signed [SUM_W-1:0]      p2_c;
	logic signed [SUM_W-1:0]      hsum;
	logic [OUT_W-1:0]             hclamp;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done         = done_q;
	assign height_q8    = height_q;
	assign out_of_range = oor_q;

	// effective geometry
	assign stride = clamp_verts(vrow_q);
	assign rows   = clamp_verts(vcol_q);
	assign sp     = (spacing_q == '0) ? SP_W'(1) : spacing_q;

	// offsets from the grid corner, z axis flipped
	assign tx = OFS_W'(pos_x) - $signed({{(OFS_W - CFG_DATA_W - FRAC_W){corner_x_q[CFG_DATA_W-1]}},
		corner_x_q, {FRAC_W{1'b0}}});
	assign tz = $signed({{(OFS_W - CFG_DATA_W - FRAC_W){corner_z_q[CFG_DATA_W-1]}},
		corner_z_q, {FRAC_W{1'b0}}}) - OFS_W'(pos_z);
	assign neg_ofs = tx[OFS_W-1] || tz[OFS_W-1];

	// one restoring divide step per axis
	assign trial_x = {remx_q, numx_q[NUM_W-1]};
	assign trial_z = {remz_q, numz_q[NUM_W-1]};
	assign ge_x    = trial_x >= {1'b0, sp};
	assign ge_z    = trial_z >= {1'b0, sp};
	assign diffx   = trial_x - {1'b0, sp};
	assign diffz   = trial_z - {1'b0, sp};

	// cell position and grid bounds
	assign col_c    = numx_q[NUM_W-1:FRAC_W];
	assign row_c    = numz_q[NUM_W-1:FRAC_W];
	assign grid_oor = (col_c >= CELL_W'(stride) - CELL_W'(1)) ||
		(row_c >= CELL_W'(rows) - CELL_W'(1));
	assign rlin = LIN_W'(row_c[VERTS_W-1:0]) * LIN_W'(stride) + LIN_W'(col_c[VERTS_W-1:0]);

	// write address
	assign wlin   = LIN_W'(entry_row) * LIN_W'(stride) + LIN_W'(entry_col);
	assign waddr  = wlin[ADDR_W-1:0];
	assign mem_we = accept && !operation && ({1'b0, wlin} < (LIN_W + 1)'(DEPTH));

	// corner read address: upper-left, upper-right, lower-left, lower-right
	always_comb begin
		case (rd_cnt_q[1:0])
			2'd0:    raddr = base_q;
			2'd1:    raddr = base_q + ADDR_W'(1);
			2'd2:    raddr = base_q + ADDR_W'(stride);
			default: raddr = base_q + ADDR_W'(stride) + ADDR_W'(1);
		endcase
	end
	assign cap_idx = rd_cnt_q - RD_CNT_W'(1);

	// triangle selection and weights
	assign fsum  = {1'b0, fx_q} + {1'b0, fz_q};
	assign upper = !fsum[FRAC_W];
	assign e_v   = upper ? corner_q[0] : corner_q[3];
	assign g1_v  = upper ? corner_q[1] : corner_q[2];
	assign g2_v  = upper ? corner_q[2] : corner_q[1];
	assign w1    = upper ? {1'b0, fx_q} : (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fx_q};
	assign w2    = upper ? {1'b0, fz_q} : (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fz_q};
	assign diff1 = $signed({1'b0, g1_v}) - $signed({1'b0, e_v});
	assign diff2 = $signed({1'b0, g2_v}) - $signed({1'b0, e_v});
	assign p1_c  = diff1 * $signed({1'b0, w1});
	assign p2_c  = diff2 * $signed({1'b0, w2});

	// final sum and clamp to the output range
	assign hsum = $signed({{(SUM_W - OUT_W){1'b0}}, basev_q}) + p1_q + p2_q;
	always_comb begin
		if (hsum[SUM_W-1])
			hclamp = '0;
		else if (hsum[SUM_W-2:OUT_W] != '0)
			hclamp = '1;
		else
			hclamp = hsum[OUT_W-1:0];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_x_q <= '0;
			corner_z_q <= '0;
			spacing_q  <= SP_W'(1);
			vrow_q     <= VERTS_W'(GRID_SIDE);
			vcol_q     <= VERTS_W'(GRID_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CORNER_X:  corner_x_q <= cfg_data;
				REG_CORNER_Z:  corner_z_q <= cfg_data;
				REG_SPACING:   spacing_q  <= cfg_data[SP_W-1:0];
				REG_VERTS_ROW: vrow_q     <= cfg_data[VERTS_W-1:0];
				REG_VERTS_COL: vcol_q     <= cfg_data[VERTS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			rd_cnt_q  <= '0;
			done_q    <= 1'b0;
			height_q  <= '0;
			oor_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!operation || neg_ofs) begin
							done_q   <= 1'b1;
							height_q <= '0;
							oor_q    <= operation;
						end else begin
							div_cnt_q <= CNT_W'(NUM_W - 1);
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - CNT_W'(1);
					if (div_cnt_q == '0)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (grid_oor) begin
						done_q   <= 1'b1;
						height_q <= '0;
						oor_q    <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						rd_cnt_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + RD_CNT_W'(1);
					if (rd_cnt_q == RD_CNT_W'(4))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					done_q   <= 1'b1;
					height_q <= hclamp;
					oor_q    <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			numx_q <= tx[NUM_W-1:0];
			numz_q <= tz[NUM_W-1:0];
			remx_q <= '0;
			remz_q <= '0;
		end else if (state_q == ST_DIV) begin
			numx_q <= {numx_q[NUM_W-2:0], ge_x};
			numz_q <= {numz_q[NUM_W-2:0], ge_z};
			remx_q <= ge_x ? diffx[SP_W-1:0] : trial_x[SP_W-1:0];
			remz_q <= ge_z ? diffz[SP_W-1:0] : trial_z[SP_W-1:0];
		end
		if (state_q == ST_CHK) begin
			base_q <= rlin[ADDR_W-1:0];
			fx_q   <= numx_q[FRAC_W-1:0];
			fz_q   <= numz_q[FRAC_W-1:0];
		end
		if (state_q == ST_READ && rd_cnt_q != '0)
			corner_q[cap_idx[1:0]] <= rd_q;
		if (state_q == ST_MUL) begin
			basev_q <= {e_v, {FRAC_W{1'b0}}};
			p1_q    <= p1_c;
			p2_q    <= p2_c;
		end
	end

	// height memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= entry_value;
		rd_q <= mem[raddr];
	end

	// checks
	`HMTH_ASSERT_NEXT(a_write_word, clk, arst_n, accept && !operation, done && !out_of_range && height_q8 == '0)
	`HMTH_ASSERT_SAME(a_oor_zero, clk, arst_n, done && out_of_range, height_q8 == '0)
	`HMTH_ASSERT_NEXT(a_div_end, clk, arst_n, (state_q == ST_DIV) && (div_cnt_q == '0), state_q == ST_CHK)

endmodule

// ===== test/heightmap_triangle_height_sample_test.sv =====
`timescale 1ns / 1ps

module heightmap_triangle_height_sample_test;
	import hmth_pkg::*;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_QUERY    = 1'b1;
	localparam int   CYCLE_LIMIT = 1_000_000;
	localparam int   PHASE_ITEMS = 230;

	typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_t;

	// one result word
	typedef struct packed {
		logic [OUT_W-1:0] height;
		logic             oor;
	} height_word_t;

	// one row of the directed stimulus
	typedef struct packed {
		logic             op;
		logic [ROW_W-1:0] row;
		logic [ROW_W-1:0] col;
		logic [HGT_W-1:0] val;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] pz;
		logic             typed;
		height_word_t     word;
	} probe_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    operation;
	logic [ROW_W-1:0]        entry_row;
	logic [ROW_W-1:0]        entry_col;
	logic [HGT_W-1:0]        entry_value;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_z;
	logic                    done;
	logic [OUT_W-1:0]        height_q8;
	logic                    out_of_range;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// shadow of the block's registers and height store
	logic signed [15:0] cfg_corner_x;
	logic signed [15:0] cfg_corner_z;
	logic [SP_W-1:0]    cfg_spacing;
	logic [VERTS_W-1:0] cfg_verts_row;
	logic [VERTS_W-1:0] cfg_verts_col;
	logic [HGT_W-1:0]   grid_heights [0:DEPTH-1];
	bit                 grid_written [0:DEPTH-1];

	height_word_t height_exp_q [$];
	probe_t       probe_q [$];
	idle_mode_t   idle_mode;
	int           burst_left;
	int           items_sent;
	int           mismatches;
	int           cycles;

	heightmap_triangle_height_sample u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.entry_row    (entry_row),
		.entry_col    (entry_col),
		.entry_value  (entry_value),
		.pos_x        (pos_x),
		.pos_z        (pos_z),
		.done         (done),
		.height_q8    (height_q8),
		.out_of_range (out_of_range),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("heightmap_triangle_height_sample_test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d (after %0d items)", what, got, want,
			items_sent);
	endtask

	// vertex count as the block uses it
	function automatic int verts_used(input logic [VERTS_W-1:0] v);
		if (v < VERTS_W'(2))
			return 2;
		if (int'(v) > GRID_SIDE)
			return GRID_SIDE;
		return int'(v);
	endfunction

	function automatic int stride_now();
		return verts_used(cfg_verts_row);
	endfunction

	function automatic int rows_now();
		return verts_used(cfg_verts_col);
	endfunction

	// find the cell and fraction of a query, 1 when it lies inside the grid
	function automatic bit locate_cell(input logic signed [POS_W-1:0] px, pz,
			output int cr, cc, fx, fz);
		longint tx;
		longint tz;
		longint sp;
		longint qx;
		longint qz;
		tx = longint'(px) - longint'(cfg_corner_x) * 256;
		tz = longint'(cfg_corner_z) * 256 - longint'(pz);
		sp = (cfg_spacing == '0) ? 1 : longint'(cfg_spacing);
		cr = 0;
		cc = 0;
		fx = 0;
		fz = 0;
		if (tx < 0 || tz < 0)
			return 1'b0;
		qx = tx / sp;
		qz = tz / sp;
		cc = int'(qx >>> 8);
		cr = int'(qz >>> 8);
		fx = int'(qx & 255);
		fz = int'(qz & 255);
		return (cc < stride_now() - 1) && (cr < rows_now() - 1);
	endfunction

	// expected word for one accepted item, updates the shadow store on writes
	function automatic height_word_t predict_height(input logic op,
			input logic [ROW_W-1:0] row, col, input logic [HGT_W-1:0] val,
			input logic signed [POS_W-1:0] px, pz);
		height_word_t w;
		int           idx;
		int           s;
		int           cr;
		int           cc;
		int           fx;
		int           fz;
		longint       a;
		longint       b;
		longint       c;
		longint       d;
		longint       h;
		w = '0;
		s = stride_now();
		if (op == OP_WRITE) begin
			idx = int'(row) * s + int'(col);
			if (idx < DEPTH) begin
				grid_heights[idx] = val;
				grid_written[idx] = 1'b1;
			end
		end else if (!locate_cell(px, pz, cr, cc, fx, fz)) begin
			w.oor = 1'b1;
		end else begin
			a = longint'(grid_heights[cr * s + cc]);
			b = longint'(grid_heights[cr * s + cc + 1]);
			c = longint'(grid_heights[(cr + 1) * s + cc]);
			d = longint'(grid_heights[(cr + 1) * s + cc + 1]);
			// upper-left triangle when the fractions sum below one
			if (fx + fz < 256)
				h = a * 256 + (b - a) * fx + (c - a) * fz;
			else
				h = d * 256 + (c - d) * (256 - fx) + (b - d) * (256 - fz);
			if (h < 0)
				h = 0;
			if (h > 64'hFFFFFF)
				h = 64'hFFFFFF;
			w.height = h[OUT_W-1:0];
		end
		return w;
	endfunction

	// random hold-off before a word, with bursts of back-to-back words
	function automatic int idle_gap();
		int n = 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0)
			burst_left = 25;
		case (idle_mode)
			IDLE_HEAVY: while ($urandom_range(0, 99) < 75 && n < 40) n++;
			IDLE_LIGHT: while ($urandom_range(0, 99) < 16 && n < 40) n++;
			default: n = 0;
		endcase
		return n;
	endfunction

	// drive one command word and queue its expected result
	task automatic send_item(input logic op, input logic [ROW_W-1:0] row, col,
			input logic [HGT_W-1:0] val, input logic signed [POS_W-1:0] px, pz,
			input logic typed, input height_word_t typed_word);
		int           gap;
		height_word_t want;
		gap = idle_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= op;
		entry_row   <= row;
		entry_col   <= col;
		entry_value <= val;
		pos_x       <= px;
		pos_z       <= pz;
		do @(posedge clk); while (busy !== 1'b0);
		want = predict_height(op, row, col, val, px, pz);
		if (typed)
			want = typed_word;
		height_exp_q.push_back(want);
		items_sent++;
	endtask

	// query, first filling any corner of its cell that was never written
	task automatic issue_query(input logic signed [POS_W-1:0] px, pz);
		int cr;
		int cc;
		int fx;
		int fz;
		int s;
		if (locate_cell(px, pz, cr, cc, fx, fz)) begin
			s = stride_now();
			for (int dr = 0; dr < 2; dr++) begin
				for (int dc = 0; dc < 2; dc++) begin
					if (!grid_written[(cr + dr) * s + cc + dc])
						send_item(OP_WRITE, ROW_W'(cr + dr), ROW_W'(cc + dc),
							HGT_W'($urandom), '0, '0, 1'b0, '0);
				end
			end
		end
		send_item(OP_QUERY, '0, '0, '0, px, pz, 1'b0, '0);
	endtask

	// one register write, valid stays high for the next one
	task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_CORNER_X:  cfg_corner_x  = data;
			REG_CORNER_Z:  cfg_corner_z  = data;
			REG_SPACING:   cfg_spacing   = data[SP_W-1:0];
			REG_VERTS_ROW: cfg_verts_row = data[VERTS_W-1:0];
			REG_VERTS_COL: cfg_verts_col = data[VERTS_W-1:0];
			default: ;
		endcase
	endtask

	// wait for the block to go idle, then load all registers
	task automatic set_config(input logic signed [15:0] cx, cz, input logic [SP_W-1:0] sp,
			input logic [VERTS_W-1:0] vr, vc);
		start <= 1'b0;
		do @(posedge clk); while (height_exp_q.size() != 0 || busy !== 1'b0);
		repeat (4) @(posedge clk);
		cfg_write(REG_CORNER_X, cx);
		cfg_write(REG_CORNER_Z, cz);
		cfg_write(REG_SPACING, CFG_DATA_W'(sp));
		cfg_write(REG_VERTS_ROW, CFG_DATA_W'(vr));
		cfg_write(REG_VERTS_COL, CFG_DATA_W'(vc));
		cfg_valid <= 1'b0;
	endtask

	// random phase: mostly queries aimed into the grid, some writes and noise
	task automatic run_phase(input logic signed [15:0] cx, cz, input logic [SP_W-1:0] sp,
			input logic [VERTS_W-1:0] vr, vc, input idle_mode_t mode);
		int     first;
		int     kind;
		int     s;
		int     rows;
		int     cc;
		int     cr;
		int     fx;
		int     fz;
		longint spc;
		longint tx;
		longint tz;
		longint px;
		longint pz;
		set_config(cx, cz, sp, vr, vc);
		idle_mode  = mode;
		burst_left = 0;
		first      = items_sent;
		s          = stride_now();
		rows       = rows_now();
		spc        = (cfg_spacing == '0) ? 1 : longint'(cfg_spacing);
		while (items_sent - first < PHASE_ITEMS) begin
			// now and then hold off until every result is back
			if (items_sent - first == 100 || $urandom_range(0, 63) == 0) begin
				start <= 1'b0;
				do @(posedge clk); while (height_exp_q.size() != 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				if ($urandom_range(0, 4) != 0)
					send_item(OP_WRITE, ROW_W'($urandom_range(0, rows - 1)),
						ROW_W'($urandom_range(0, s - 1)), HGT_W'($urandom), '0, '0,
						1'b0, '0);
				else
					send_item(OP_WRITE, ROW_W'($urandom), ROW_W'($urandom),
						HGT_W'($urandom), POS_W'($urandom), POS_W'($urandom), 1'b0, '0);
			end else if (kind < 88) begin
				// aimed query, sometimes on the far edge or the triangle seam
				cc = ($urandom_range(0, 7) == 0) ? s - 1 + $urandom_range(0, 1)
					: $urandom_range(0, s - 2);
				cr = ($urandom_range(0, 7) == 0) ? rows - 1 + $urandom_range(0, 1)
					: $urandom_range(0, rows - 2);
				fx = $urandom_range(0, 255);
				fz = $urandom_range(0, 255);
				if ($urandom_range(0, 3) == 0)
					fz = (256 - fx - $urandom_range(0, 1)) & 255;
				tx = longint'((cc << 8) | fx) * spc + $urandom_range(0, int'(spc) - 1);
				tz = longint'((cr << 8) | fz) * spc + $urandom_range(0, int'(spc) - 1);
				if ($urandom_range(0, 15) == 0)
					tx = -longint'($urandom_range(1, 300));
				if ($urandom_range(0, 15) == 0)
					tz = -longint'($urandom_range(1, 300));
				px = tx + longint'(cfg_corner_x) * 256;
				pz = longint'(cfg_corner_z) * 256 - tz;
				if (px < -(64'sd1 << 23) || px >= (64'sd1 << 23))
					px = longint'($urandom);
				if (pz < -(64'sd1 << 23) || pz >= (64'sd1 << 23))
					pz = longint'($urandom);
				issue_query(POS_W'(px), POS_W'(pz));
			end else begin
				issue_query(POS_W'($urandom), POS_W'($urandom));
			end
		end
	endtask

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		height_word_t want;
		if (arst_n && done === 1'b1) begin
			if (height_exp_q.size() == 0) begin
				report_mismatch("unexpected word, height", height_q8, 0);
			end else begin
				want = height_exp_q.pop_front();
				if (height_q8 !== want.height)
					report_mismatch("height_q8", height_q8, want.height);
				if (out_of_range !== want.oor)
					report_mismatch("out_of_range", out_of_range, want.oor);
			end
		end
	end

	// stimulus
	initial begin
		probe_t p;
		cycles        = 0;
		mismatches    = 0;
		items_sent    = 0;
		burst_left    = 0;
		idle_mode     = IDLE_NONE;
		cfg_corner_x  = '0;
		cfg_corner_z  = '0;
		cfg_spacing   = SP_W'(1);
		cfg_verts_row = VERTS_W'(GRID_SIDE);
		cfg_verts_col = VERTS_W'(GRID_SIDE);
		for (int i = 0; i < DEPTH; i++) begin
			grid_heights[i] = '0;
			grid_written[i] = 1'b0;
		end
		arst_n      <= 1'b0;
		start       <= 1'b0;
		operation   <= OP_WRITE;
		entry_row   <= '0;
		entry_col   <= '0;
		entry_value <= '0;
		pos_x       <= '0;
		pos_z       <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_CORNER_X;
		cfg_data    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset settings: unit spacing, 64 by 64 grid
		// first cell corners, then corner, both triangles, every way out of the grid
		probe_q.push_back({OP_WRITE, 6'd0, 6'd0, 16'd100, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd0, 6'd1, 16'd200, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd1, 6'd0, 16'd300, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd1, 6'd1, 16'd400, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd0, 24'd0, 1'b1, 24'd25600, 1'b0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd128, -24'sd128, 1'b0, 25'd0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd64, -24'sd64, 1'b0, 25'd0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd255, 24'd0, 1'b0, 25'd0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, -24'sd1, 24'd0, 1'b1, 24'd0, 1'b1});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd0, 24'd1, 1'b1, 24'd0, 1'b1});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd16128, 24'd0, 1'b1, 24'd0, 1'b1});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd0, -24'sd16128, 1'b1, 24'd0,
			1'b1});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'h7FFFFF, 24'h800000, 1'b1, 24'd0,
			1'b1});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'h800000, 24'h7FFFFF, 1'b1, 24'd0,
			1'b1});
		// last cell at full height, then one corner dropped to zero
		probe_q.push_back({OP_WRITE, 6'd63, 6'd63, 16'hFFFF, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd62, 6'd62, 16'hFFFF, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd62, 6'd63, 16'hFFFF, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd63, 6'd62, 16'hFFFF, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd16127, -24'sd16127, 1'b1,
			24'd16776960, 1'b0});
		probe_q.push_back({OP_WRITE, 6'd62, 6'd62, 16'd0, 24'd0, 24'd0, 1'b1, 24'd0, 1'b0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd15872, -24'sd15872, 1'b1, 24'd0,
			1'b0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd16127, -24'sd16127, 1'b0, 25'd0});
		probe_q.push_back({OP_QUERY, 6'd0, 6'd0, 16'd0, 24'd16072, -24'sd15882, 1'b0, 25'd0});
		foreach (probe_q[i]) begin
			p = probe_q[i];
			send_item(p.op, p.row, p.col, p.val, p.px, p.pz, p.typed, p.word);
		end

		// random phases across register settings and idle patterns
		run_phase(16'sd0, 16'sd0, 8'd1, 7'd64, 7'd64, IDLE_NONE);
		run_phase(-16'sd32768, 16'sd32767, 8'd255, 7'd2, 7'd2, IDLE_HEAVY);
		run_phase(16'sd32767, -16'sd32768, 8'd0, 7'd127, 7'd0, IDLE_LIGHT);
		run_phase(16'sd100, -16'sd50, 8'd16, 7'd10, 7'd20, IDLE_HEAVY);
		run_phase(-16'sd5, 16'sd7, 8'd3, 7'd33, 7'd64, IDLE_LIGHT);
		run_phase(16'sd0, 16'sd0, 8'd255, 7'd64, 7'd64, IDLE_NONE);
		run_phase(-16'sd1000, 16'sd1000, 8'd1, 7'd1, 7'd65, IDLE_HEAVY);

		// drain and settle
		start <= 1'b0;
		for (int k = 0; k < 2000 && height_exp_q.size() != 0; k++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (height_exp_q.size() != 0)
			report_mismatch("words never returned", height_exp_q.size(), 0);
		if (mismatches == 0)
			$display("heightmap_triangle_height_sample_test passed");
		else
			$display("heightmap_triangle_height_sample_test failed");
		$finish;
	end

endmodule
